[sv/calu_pkg.sv]
// Shared types and constants for the 8-bit flag ALU pipeline.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package calu_pkg;

  // Operation codes
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLC   = 5'd10,
    OP_RRC   = 5'd11,
    OP_RL    = 5'd12,
    OP_RR    = 5'd13,
    OP_SLA   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SRL   = 5'd16,
    OP_SWAP  = 5'd17,
    OP_BIT   = 5'd18,
    OP_RES   = 5'd19,
    OP_SET   = 5'd20,
    OP_DAA   = 5'd21,
    OP_ADD16 = 5'd22,
    OP_INC16 = 5'd23,
    OP_DEC16 = 5'd24
  } op_e;

  // Flag bit positions in the 4-bit flag word
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [7:0] DAA_ADJ_LO = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI = 8'h60;
  localparam logic [7:0] BCD_BYTE_MAX = 8'h99;
  localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;

  // Decode stage payload: operands plus the prepared adder input
  typedef struct packed {
    op_e         op;
    logic [15:0] a;
    logic [15:0] b;
    logic [7:0]  b_add;
    logic        cin;
    logic [2:0]  bi;
    logic [3:0]  fin;
  } dec_t;

  // Execute stage payload: result word and partial flags
  typedef struct packed {
    logic [15:0] res;
    logic        z_byte;
    logic        z_alt;
    logic        n;
    logic        h;
    logic        c;
  } ex_t;

endpackage

`default_nettype wire

[sv/cpu_alu_8bit_flags.sv]
// 8-bit ALU with Z, N, H, C flags, three register stages: decode, execute, flags.
// Each item is registered in decode, then execute, then the flag stage, which drives the outputs.
// Throughput: one item per cycle while out_ready holds; each stage loads whenever it is empty or draining.
// Reset: synchronous, active low; clears the stage valid bits only.
// Depends on calu_pkg, calu_decode, calu_exec and calu_flags.
`default_nettype none

module cpu_alu_8bit_flags (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_op,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  input  wire logic [2:0]  in_bit_index,
  input  wire logic [3:0]  in_flags_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_result,
  output logic [3:0]       out_flags_out
);
  import calu_pkg::*;

  logic dec_valid;
  logic dec_ready;
  dec_t dec;
  logic ex_valid;
  logic ex_ready;
  ex_t  ex;

  // Decode stage
  calu_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_bit_index (in_bit_index),
    .in_flags_in  (in_flags_in),
    .dec_valid    (dec_valid),
    .dec_ready    (dec_ready),
    .dec          (dec)
  );

  // Execute stage
  calu_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .ex_valid  (ex_valid),
    .ex_ready  (ex_ready),
    .ex        (ex)
  );

  // Flag stage and output register
  calu_flags u_flags (
    .clk           (clk),
    .rst_n         (rst_n),
    .ex_valid      (ex_valid),
    .ex_ready      (ex_ready),
    .ex            (ex),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result    (out_result),
    .out_flags_out (out_flags_out)
  );

endmodule

`default_nettype wire

[sv/calu_decode.sv]
// Stage 1: register the incoming item and prepare the shared 8-bit adder input.
// Depends on calu_pkg.
`default_nettype none

module calu_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [4:0]    in_op,
  input  wire logic [15:0]   in_operand_a,
  input  wire logic [15:0]   in_operand_b,
  input  wire logic [2:0]    in_bit_index,
  input  wire logic [3:0]    in_flags_in,
  output logic               dec_valid,
  input  wire logic          dec_ready,
  output calu_pkg::dec_t     dec
);
  import calu_pkg::*;

  logic valid_r;
  dec_t dec_r;
  dec_t dec_nxt;

  // Stage may load when empty or when its item moves on
  assign in_ready = !valid_r || dec_ready;

  // Choose the addend and carry so add, sub, inc and dec share one adder
  always_comb begin
    dec_nxt.op    = op_e'(in_op);
    dec_nxt.a     = in_operand_a;
    dec_nxt.b     = in_operand_b;
    dec_nxt.b_add = in_operand_b[7:0];
    dec_nxt.cin   = 1'b0;
    dec_nxt.bi    = in_bit_index;
    dec_nxt.fin   = in_flags_in;
    unique case (op_e'(in_op)) inside
      OP_ADC: begin
        dec_nxt.cin = in_flags_in[FLAG_C];
      end
      OP_SUB, OP_CP: begin
        dec_nxt.b_add = ~in_operand_b[7:0];
        dec_nxt.cin   = 1'b1;
      end
      OP_SBC: begin
        dec_nxt.b_add = ~in_operand_b[7:0];
        dec_nxt.cin   = ~in_flags_in[FLAG_C];
      end
      OP_INC: begin
        dec_nxt.b_add = 8'h01;
      end
      OP_DEC: begin
        dec_nxt.b_add = 8'hFE;
        dec_nxt.cin   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold valid under reset; advance when the stage is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Load the item payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec       = dec_r;

endmodule

`default_nettype wire

[sv/calu_exec.sv]
// Stage 2: compute the result word, the carry, half carry and N flags, and the zero-flag inputs.
// Depends on calu_pkg.
`default_nettype none

module calu_exec (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          dec_valid,
  output logic               dec_ready,
  input  wire calu_pkg::dec_t dec,
  output logic               ex_valid,
  input  wire logic          ex_ready,
  output calu_pkg::ex_t      ex
);
  import calu_pkg::*;

  logic        valid_r;
  ex_t         ex_r;
  ex_t         ex_nxt;
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [8:0]  sum9;
  logic [4:0]  half5;
  logic [16:0] sum17;
  logic [12:0] half13;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_res;

  assign dec_ready = !valid_r || ex_ready;

  assign a8 = dec.a[7:0];
  assign b8 = dec.b[7:0];

  // Shared 8-bit adder and low-nibble carry
  assign sum9  = {1'b0, a8} + {1'b0, dec.b_add} + {8'd0, dec.cin};
  assign half5 = {1'b0, a8[3:0]} + {1'b0, dec.b_add[3:0]} + {4'd0, dec.cin};

  // 16-bit adder with carry out of bit 11
  assign sum17  = {1'b0, dec.a} + {1'b0, dec.b};
  assign half13 = {1'b0, dec.a[11:0]} + {1'b0, dec.b[11:0]};

  // Decimal adjust: after a subtraction only the incoming flags decide
  assign daa_hi  = dec.fin[FLAG_C] || (!dec.fin[FLAG_N] && (a8 > BCD_BYTE_MAX));
  assign daa_lo  = dec.fin[FLAG_H] || (!dec.fin[FLAG_N] && (a8[3:0] > BCD_DIGIT_MAX));
  assign daa_adj = (daa_hi ? DAA_ADJ_HI : 8'h00) | (daa_lo ? DAA_ADJ_LO : 8'h00);
  assign daa_res = dec.fin[FLAG_N] ? (a8 - daa_adj) : (a8 + daa_adj);

  // Result and flags per operation; unused codes pass operand and flags
  always_comb begin
    ex_nxt.res    = dec.a;
    ex_nxt.z_byte = 1'b0;
    ex_nxt.z_alt  = dec.fin[FLAG_Z];
    ex_nxt.n      = dec.fin[FLAG_N];
    ex_nxt.h      = dec.fin[FLAG_H];
    ex_nxt.c      = dec.fin[FLAG_C];
    unique case (dec.op) inside
      OP_ADD, OP_ADC: begin
        ex_nxt.res    = {8'h00, sum9[7:0]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = half5[4];
        ex_nxt.c      = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        ex_nxt.res    = (dec.op == OP_CP) ? dec.a : {8'h00, sum9[7:0]};
        ex_nxt.z_byte = 1'b0;
        ex_nxt.z_alt  = (sum9[7:0] == 8'h00);
        ex_nxt.n      = 1'b1;
        ex_nxt.h      = !half5[4];
        ex_nxt.c      = !sum9[8];
      end
      OP_AND: begin
        ex_nxt.res    = {8'h00, a8 & b8};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b1;
        ex_nxt.c      = 1'b0;
      end
      OP_OR: begin
        ex_nxt.res    = {8'h00, a8 | b8};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = 1'b0;
      end
      OP_XOR: begin
        ex_nxt.res    = {8'h00, a8 ^ b8};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = 1'b0;
      end
      OP_INC: begin
        ex_nxt.res    = {8'h00, sum9[7:0]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = half5[4];
      end
      OP_DEC: begin
        ex_nxt.res    = {8'h00, sum9[7:0]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b1;
        ex_nxt.h      = !half5[4];
      end
      OP_RLC: begin
        ex_nxt.res    = {8'h00, a8[6:0], a8[7]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = a8[7];
      end
      OP_RRC: begin
        ex_nxt.res    = {8'h00, a8[0], a8[7:1]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = a8[0];
      end
      OP_RL: begin
        ex_nxt.res    = {8'h00, a8[6:0], dec.fin[FLAG_C]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = a8[7];
      end
      OP_RR: begin
        ex_nxt.res    = {8'h00, dec.fin[FLAG_C], a8[7:1]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = a8[0];
      end
      OP_SLA: begin
        ex_nxt.res    = {8'h00, a8[6:0], 1'b0};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = a8[7];
      end
      OP_SRA: begin
        ex_nxt.res    = {8'h00, a8[7], a8[7:1]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = a8[0];
      end
      OP_SRL: begin
        ex_nxt.res    = {8'h00, 1'b0, a8[7:1]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = a8[0];
      end
      OP_SWAP: begin
        ex_nxt.res    = {8'h00, a8[3:0], a8[7:4]};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = 1'b0;
      end
      OP_BIT: begin
        ex_nxt.z_alt  = !a8[dec.bi];
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = 1'b1;
      end
      OP_RES: begin
        ex_nxt.res    = {8'h00, a8 & ~(8'h01 << dec.bi)};
      end
      OP_SET: begin
        ex_nxt.res    = {8'h00, a8 | (8'h01 << dec.bi)};
      end
      OP_DAA: begin
        ex_nxt.res    = {8'h00, daa_res};
        ex_nxt.z_byte = 1'b1;
        ex_nxt.h      = 1'b0;
        ex_nxt.c      = daa_hi;
      end
      OP_ADD16: begin
        ex_nxt.res    = sum17[15:0];
        ex_nxt.n      = 1'b0;
        ex_nxt.h      = half13[12];
        ex_nxt.c      = sum17[16];
      end
      OP_INC16: begin
        ex_nxt.res    = dec.a + 16'd1;
      end
      OP_DEC16: begin
        ex_nxt.res    = dec.a - 16'd1;
      end
      default: begin
      end
    endcase
  end

  // Hold valid under reset; advance when the stage is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dec_ready) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid && dec_ready) begin
      ex_r <= ex_nxt;
    end
  end

  assign ex_valid = valid_r;
  assign ex       = ex_r;

endmodule

`default_nettype wire

[sv/calu_flags.sv]
// Stage 3: form the zero flag, pack the flag word and hold the output register.
// Depends on calu_pkg.
`default_nettype none

module calu_flags (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ex_valid,
  output logic               ex_ready,
  input  wire calu_pkg::ex_t ex,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        out_result,
  output logic [3:0]         out_flags_out
);
  import calu_pkg::*;

  logic        valid_r;
  logic [15:0] result_r;
  logic [3:0]  flags_r;
  logic        z_nxt;
  logic [3:0]  flags_nxt;

  assign ex_ready = !valid_r || out_ready;

  // Zero flag comes from the result byte or from the execute stage
  assign z_nxt     = ex.z_byte ? (ex.res[7:0] == 8'h00) : ex.z_alt;
  assign flags_nxt = {z_nxt, ex.n, ex.h, ex.c};

  // Hold valid under reset; once the item is taken, reload it from the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ex_ready) begin
      valid_r <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_valid && ex_ready) begin
      result_r <= ex.res;
      flags_r  <= flags_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_result    = result_r;
  assign out_flags_out = flags_r;

endmodule

`default_nettype wire

[sv/cpu_alu_8bit_flags_chk.sv]
// Port-level checker for the ALU pipeline, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module cpu_alu_8bit_flags_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_result,
  input wire logic [3:0]  out_flags_out
);

  // Hold a stalled result in place
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_flags_out))
    else $error("stalled result changed or vanished");

  // An empty output register means the whole pipe can advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // An accepted item passes the decode, execute and flag registers to the output while out_ready stays high
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item did not appear after three cycles");

  // No result appears without some earlier input
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid, 3) || $past(in_valid, 4) || !$past(rst_n, 3)
      || $past(out_valid, 1) || !$past(out_ready, 1) || $past(in_valid, 2))
    else $error("result appeared with no item in flight");

endmodule

bind cpu_alu_8bit_flags cpu_alu_8bit_flags_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_result    (out_result),
  .out_flags_out (out_flags_out)
);

`default_nettype wire
